// File: hw/rtl/dpfm_pkg.sv
// ----------------------------------------------------------------------------
// Demand page frame manager package
// Shared sizes, item types, register indexes and sequencer states.
// ----------------------------------------------------------------------------
`default_nettype none

package dpfm_pkg;

  localparam int unsigned NUM_FRAMES = 32;
  localparam int unsigned NUM_VPAGES = 64;
  localparam int unsigned PAGE_SIZE  = 128;

  localparam int unsigned ADDR_W     = 13;
  localparam int unsigned TIME_W     = 32;
  localparam int unsigned FRAME_W    = 5;
  localparam int unsigned VPN_W      = 6;
  localparam int unsigned PAGE_SHIFT = $clog2(PAGE_SIZE);
  localparam int unsigned FCNT_W     = $clog2(NUM_FRAMES + 1);
  localparam int unsigned QUOTA_W    = 6;
  localparam int unsigned CFG_IDX_W  = 1;
  localparam int unsigned CFG_DATA_W = 6;

  localparam logic [QUOTA_W-1:0] QUOTA_RESET = QUOTA_W'(32);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_FRAME_QUOTA = 1'b0,
    CFG_FIFO_MODE   = 1'b1
  } cfg_idx_e;

  typedef enum logic {
    OP_FAULT = 1'b0,
    OP_REF   = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_DECIDE,
    ST_SCAN,
    ST_SCAN_END,
    ST_VICTIM,
    ST_MAP,
    ST_DONE
  } dpfm_state_e;

  typedef struct packed {
    logic              operation;
    logic [ADDR_W-1:0] fault_address;
    logic              is_write;
    logic [TIME_W-1:0] now_ticks;
  } in_item_t;

  typedef struct packed {
    logic [FRAME_W-1:0] frame;
    logic               mapped;
    logic               evicted;
    logic [VPN_W-1:0]   evicted_page;
    logic               write_back;
    logic               no_victim;
  } out_item_t;

endpackage

`default_nettype wire

// File: hw/rtl/dpfm_if.sv
// ----------------------------------------------------------------------------
// Demand page frame manager channels
// Valid/ready channels for fault and reference items and for their results.
// ----------------------------------------------------------------------------
`default_nettype none

interface dpfm_in_if import dpfm_pkg::*; ();
  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpfm_out_if import dpfm_pkg::*; ();
  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/dpfm_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module dpfm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output      logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

`default_nettype wire

// File: hw/rtl/demand_page_frame_manager_top.sv
// ----------------------------------------------------------------------------
// Demand page frame manager
// A fault transaction on in_i maps its page to the lowest free frame while the
// quota lasts, and otherwise replaces the valid page with the oldest access
// time (or oldest arrival time in FIFO mode) that is older than now_ticks.
// A reference transaction updates the access time and dirty mark of a
// resident page. Each input transaction gives exactly one result on out_o.
// Input is taken only while the sequencer is idle. Hits, references and
// ignored addresses pass lookup, decide and done; a free frame allocation
// adds the map state, and a replacement scans the page table, one entry a
// cycle, then passes scan end, victim and (if one is found) map. The next
// transaction is taken in the cycle after the result is loaded.
// Results sit in an output register; if it is still occupied, the sequencer
// holds in its final state until the receiver takes the pending result.
// Reset clears the valid, dirty and in-use flags at once and loads the quota
// with 32; no memory clearing pass is needed.
// ----------------------------------------------------------------------------
`default_nettype none

module demand_page_frame_manager_top import dpfm_pkg::*; (
  input  wire logic                  clk_i,
  input  wire logic                  rst_ni,
  input  wire logic                  cfg_we_i,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata_i,
  dpfm_in_if.sink                    in_i,
  dpfm_out_if.source                 out_o
);

  dpfm_state_e state_q, state_d;

  logic               op_q, op_d;
  logic [VPN_W-1:0]   vpn_q, vpn_d;
  logic               in_range_q, in_range_d;
  logic               wr_q, wr_d;
  logic [TIME_W-1:0]  now_q, now_d;

  logic [QUOTA_W-1:0]    quota_q, quota_d;
  logic                  fifo_q, fifo_d;
  logic [FCNT_W-1:0]     free_cnt_q, free_cnt_d;
  logic [NUM_FRAMES-1:0] in_use_q, in_use_d;
  logic [NUM_VPAGES-1:0] valid_q, valid_d;
  logic [NUM_VPAGES-1:0] dirty_q, dirty_d;
  logic [NUM_VPAGES-1:0] la_wr_q, la_wr_d;

  logic [VPN_W-1:0]   cnt_q, cnt_d;
  logic               cmp_vld_q, cmp_vld_d;
  logic [VPN_W-1:0]   cmp_idx_q, cmp_idx_d;
  logic [TIME_W-1:0]  best_q, best_d;
  logic               found_q, found_d;
  logic [VPN_W-1:0]   slot_q, slot_d;
  logic [FRAME_W-1:0] vframe_q, vframe_d;
  logic               vdirty_q, vdirty_d;
  logic [FRAME_W-1:0] phys_q, phys_d;

  out_item_t res_q, res_d;
  out_item_t out_q, out_d;
  logic      out_vld_q, out_vld_d;

  logic [VPN_W-1:0]   ram_raddr;
  logic [FRAME_W-1:0] frame_rdata;
  logic [TIME_W-1:0]  arr_rdata;
  logic [TIME_W-1:0]  la_rdata;
  logic               map_we;
  logic               la_we;

  logic               in_acc;
  logic               out_free;
  logic               free_hit;
  logic [FRAME_W-1:0] free_idx;
  logic               alloc_ok;
  logic               page_hit;
  logic [TIME_W-1:0]  scan_time;
  logic [ADDR_W-1:0]  vpn_full;

  assign in_i.ready  = (state_q == ST_IDLE);
  assign in_acc      = in_i.valid && in_i.ready;
  assign out_o.valid = out_vld_q;
  assign out_o.data  = out_q;
  assign out_free    = !out_vld_q || out_o.ready;
  assign page_hit    = valid_q[vpn_q];
  assign vpn_full    = in_i.data.fault_address >> PAGE_SHIFT;

  always_comb begin
    free_hit = 1'b0;
    free_idx = '0;
    for (int i = NUM_FRAMES - 1; i >= 0; i--) begin
      if (!in_use_q[i]) begin
        free_hit = 1'b1;
        free_idx = FRAME_W'(i);
      end
    end
  end

  assign alloc_ok  = (quota_q != '0) && (free_cnt_q != '0) && free_hit;
  assign scan_time = fifo_q ? arr_rdata : (la_wr_q[cmp_idx_q] ? la_rdata : '0);
  assign ram_raddr = (state_q == ST_SCAN) ? cnt_q : vpn_q;

  dpfm_ram #(.WIDTH(FRAME_W), .DEPTH(NUM_VPAGES)) u_frame_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (vpn_q),
    .wdata_i (phys_q),
    .raddr_i (ram_raddr),
    .rdata_o (frame_rdata)
  );

  dpfm_ram #(.WIDTH(TIME_W), .DEPTH(NUM_VPAGES)) u_arrival_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (vpn_q),
    .wdata_i (now_q),
    .raddr_i (ram_raddr),
    .rdata_o (arr_rdata)
  );

  dpfm_ram #(.WIDTH(TIME_W), .DEPTH(NUM_VPAGES)) u_access_ram (
    .clk_i   (clk_i),
    .we_i    (la_we),
    .waddr_i (vpn_q),
    .wdata_i (now_q),
    .raddr_i (ram_raddr),
    .rdata_o (la_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          state_d = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!in_range_q || (op_q == OP_REF) || page_hit) begin
          state_d = ST_DONE;
        end else if (alloc_ok) begin
          state_d = ST_MAP;
        end else begin
          state_d = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (cnt_q == VPN_W'(NUM_VPAGES - 1)) begin
          state_d = ST_SCAN_END;
        end
      end
      ST_SCAN_END: begin
        state_d = ST_VICTIM;
      end
      ST_VICTIM: begin
        state_d = found_q ? ST_MAP : ST_DONE;
      end
      ST_MAP: begin
        state_d = ST_DONE;
      end
      ST_DONE: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    op_d       = op_q;
    vpn_d      = vpn_q;
    in_range_d = in_range_q;
    wr_d       = wr_q;
    now_d      = now_q;
    quota_d    = quota_q;
    fifo_d     = fifo_q;
    free_cnt_d = free_cnt_q;
    in_use_d   = in_use_q;
    valid_d    = valid_q;
    dirty_d    = dirty_q;
    la_wr_d    = la_wr_q;
    cnt_d      = cnt_q;
    cmp_vld_d  = (state_q == ST_SCAN);
    cmp_idx_d  = cnt_q;
    best_d     = best_q;
    found_d    = found_q;
    slot_d     = slot_q;
    vframe_d   = vframe_q;
    vdirty_d   = vdirty_q;
    phys_d     = phys_q;
    res_d      = res_q;
    out_d      = out_q;
    out_vld_d  = out_vld_q && !out_o.ready;
    map_we     = 1'b0;
    la_we      = 1'b0;

    if (cmp_vld_q && valid_q[cmp_idx_q] && (scan_time < best_q)) begin
      best_d   = scan_time;
      found_d  = 1'b1;
      slot_d   = cmp_idx_q;
      vframe_d = frame_rdata;
      vdirty_d = dirty_q[cmp_idx_q];
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_d       = in_i.data.operation;
          vpn_d      = vpn_full[VPN_W-1:0];
          in_range_d = (vpn_full < ADDR_W'(NUM_VPAGES));
          wr_d       = in_i.data.is_write;
          now_d      = in_i.data.now_ticks;
        end
      end
      ST_DECIDE: begin
        res_d = '0;
        if (!in_range_q) begin
          res_d = '0;
        end else if (op_q == OP_REF) begin
          if (page_hit) begin
            la_we          = 1'b1;
            la_wr_d[vpn_q] = 1'b1;
            if (wr_q) begin
              dirty_d[vpn_q] = 1'b1;
            end
            res_d.frame  = frame_rdata;
            res_d.mapped = 1'b1;
          end
        end else if (page_hit) begin
          res_d.frame  = frame_rdata;
          res_d.mapped = 1'b1;
        end else if (alloc_ok) begin
          in_use_d[free_idx] = 1'b1;
          free_cnt_d         = free_cnt_q - FCNT_W'(1);
          quota_d            = quota_q - QUOTA_W'(1);
          phys_d             = free_idx;
        end else begin
          best_d  = now_q;
          found_d = 1'b0;
          cnt_d   = '0;
        end
      end
      ST_SCAN: begin
        cnt_d = cnt_q + VPN_W'(1);
      end
      ST_VICTIM: begin
        if (found_q) begin
          valid_d[slot_q]    = 1'b0;
          res_d.evicted      = 1'b1;
          res_d.evicted_page = slot_q;
          res_d.write_back   = vdirty_q;
          phys_d             = vframe_q;
        end else begin
          res_d.no_victim = 1'b1;
        end
      end
      ST_MAP: begin
        map_we         = 1'b1;
        valid_d[vpn_q] = 1'b1;
        dirty_d[vpn_q] = 1'b0;
        res_d.frame    = phys_q;
        res_d.mapped   = 1'b1;
      end
      ST_DONE: begin
        if (out_free) begin
          out_d     = res_q;
          out_vld_d = 1'b1;
        end
      end
      default: begin
      end
    endcase

    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_FRAME_QUOTA: quota_d = cfg_wdata_i[QUOTA_W-1:0];
        CFG_FIFO_MODE:   fifo_d  = cfg_wdata_i[0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= ST_IDLE;
      quota_q    <= QUOTA_RESET;
      fifo_q     <= 1'b0;
      free_cnt_q <= FCNT_W'(NUM_FRAMES);
      in_use_q   <= '0;
      valid_q    <= '0;
      dirty_q    <= '0;
      la_wr_q    <= '0;
      cmp_vld_q  <= 1'b0;
      out_vld_q  <= 1'b0;
    end else begin
      state_q    <= state_d;
      quota_q    <= quota_d;
      fifo_q     <= fifo_d;
      free_cnt_q <= free_cnt_d;
      in_use_q   <= in_use_d;
      valid_q    <= valid_d;
      dirty_q    <= dirty_d;
      la_wr_q    <= la_wr_d;
      cmp_vld_q  <= cmp_vld_d;
      out_vld_q  <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q       <= op_d;
    vpn_q      <= vpn_d;
    in_range_q <= in_range_d;
    wr_q       <= wr_d;
    now_q      <= now_d;
    cnt_q      <= cnt_d;
    cmp_idx_q  <= cmp_idx_d;
    best_q     <= best_d;
    found_q    <= found_d;
    slot_q     <= slot_d;
    vframe_q   <= vframe_d;
    vdirty_q   <= vdirty_d;
    phys_q     <= phys_d;
    res_q      <= res_d;
    out_q      <= out_d;
  end

`ifndef ASSERT_OFF
  a_free_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (int'(free_cnt_q) + $countones(in_use_q)) == NUM_FRAMES)
    else $error("free frame count disagrees with in-use flags");

  a_no_victim_unmapped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !(out_o.data.no_victim && out_o.data.mapped))
    else $error("result both mapped and without victim");

  a_write_back_evicted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_o.valid && out_o.data.write_back) |-> (out_o.data.evicted && out_o.data.mapped))
    else $error("write-back flagged without an eviction");

  a_victim_maps: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_VICTIM && found_q) |=> (state_q == ST_MAP))
    else $error("found victim not followed by mapping");
`endif

endmodule

`default_nettype wire
